FILE: src/lctd_pkg.sv
// ----------------------------------------------------------------------------
// lctd_pkg
// Shared types and codes of the least-cost task dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none

package lctd_pkg;

    localparam int TOTAL_W = 22;
    localparam int CFG_W   = 10;

    // operation codes
    localparam logic OP_SUBMIT   = 1'b0;
    localparam logic OP_COMPLETE = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_ACCEPTED = 2'd0;
    localparam logic [1:0] STATUS_NO_QUEUE = 2'd1;
    localparam logic [1:0] STATUS_POPPED   = 2'd2;
    localparam logic [1:0] STATUS_EMPTY    = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_ACTIVE_QUEUES = 2'd0;
    localparam logic [1:0] CFG_ENABLE_MASK   = 2'd1;
    localparam logic [1:0] CFG_COST_CEILING  = 2'd2;

    // configuration reset values
    localparam logic [3:0] ACTIVE_QUEUES_RST = 4'd8;
    localparam logic [7:0] ENABLE_MASK_RST   = 8'hFF;
    localparam logic [9:0] COST_CEILING_RST  = 10'd16;

    typedef struct packed {
        logic               op;
        logic [31:0]        task_handle;
        logic signed [15:0] task_cost;
        logic [2:0]         queue_select;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  queue_index;
        logic [31:0] popped_handle;
        logic [15:0] popped_cost;
    } out_item_t;

    // control from the sequencer to the minimum picker
    typedef struct packed {
        logic clear;
        logic cand;
    } pick_ctl_t;

endpackage

`default_nettype wire

FILE: src/lctd_ram.sv
// ----------------------------------------------------------------------------
// lctd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lctd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: src/lctd_qstate.sv
// ----------------------------------------------------------------------------
// lctd_qstate
// Per-queue state store: RAM plus a valid bit per entry, so that an entry
// never written since reset reads as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module lctd_qstate #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;
    logic             rd_vld_reg;
    logic             rd_vld_next;
    logic [WIDTH-1:0] ram_rd;

    lctd_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_rd)
    );

    always_comb
    begin
        vld_next = vld_reg;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (wr_en && (wr_addr == AW'(i)))
            begin
                vld_next[i] = 1'b1;
            end
        end
        rd_vld_next = rd_en ? vld_reg[rd_addr] : rd_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg    <= vld_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    assign rd_data = rd_vld_reg ? ram_rd : '0;

endmodule

`default_nettype wire

FILE: src/lctd_picker.sv
// ----------------------------------------------------------------------------
// lctd_picker
// Running minimum over a stream of candidates; first of equal keys is kept.
// ----------------------------------------------------------------------------
`default_nettype none

module lctd_picker
    import lctd_pkg::*;
#(
    parameter int KEY_W = 22,
    parameter int PAY_W = 36,
    parameter int IDX_W = 3
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire pick_ctl_t        ctl,
    input  wire logic [KEY_W-1:0] key,
    input  wire logic [IDX_W-1:0] idx,
    input  wire logic [PAY_W-1:0] payload,
    output logic                  found,
    output logic      [IDX_W-1:0] best_idx,
    output logic      [PAY_W-1:0] best_payload
);

    logic             found_reg;
    logic             found_next;
    logic [KEY_W-1:0] best_key_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [PAY_W-1:0] best_pay_reg;
    logic             take;

    // strict compare: candidates arrive in ascending index order
    assign take = ctl.cand && (!found_reg || (key < best_key_reg));

    always_comb
    begin
        if (ctl.clear)
        begin
            found_next = 1'b0;
        end
        else
        begin
            found_next = found_reg | ctl.cand;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_key_reg <= key;
            best_idx_reg <= idx;
            best_pay_reg <= payload;
        end
    end

    assign found        = found_reg;
    assign best_idx     = best_idx_reg;
    assign best_payload = best_pay_reg;

endmodule

`default_nettype wire

FILE: src/least_cost_task_dispatcher.sv
// ----------------------------------------------------------------------------
// least_cost_task_dispatcher
// Weighted task dispatch over per-worker ring queues, least total cost wins.
// ----------------------------------------------------------------------------
// One item is handled at a time. A submit scans the active queues through
// the queue-state memory, one queue per cycle, keeping the running minimum,
// then, if a queue qualifies, writes the ring memory and the winner's state.
// A complete to a valid queue reads the queue state and, if the queue is not
// empty, then the ring slot (two dependent memory reads) and writes the state
// back. Queue state resets through per-entry valid bits, so no clearing pass
// follows reset. A result waits in the output register until taken; the next
// item is accepted once it has moved there.
// ----------------------------------------------------------------------------
`default_nettype none

module least_cost_task_dispatcher
    import lctd_pkg::*;
#(
    parameter int NUM_QUEUES = 8,
    parameter int RING_DEPTH = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire in_item_t         in_data,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output out_item_t             out_data,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    localparam int QW     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PW     = $clog2(2 * RING_DEPTH);
    localparam int FW     = PW + 1;
    localparam int SW     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int RDEP   = NUM_QUEUES * RING_DEPTH;
    localparam int RAW    = (RDEP > 1) ? $clog2(RDEP) : 1;
    localparam int CW     = $clog2(NUM_QUEUES + 1);
    localparam int THW    = CFG_W + PW;
    localparam int CHW    = (THW > 16) ? THW : 16;
    localparam int ENT_W  = 2 * PW + TOTAL_W;
    localparam int RING_W = 48;

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_START    = 8'b0000_0010,
        ST_SCAN     = 8'b0000_0100,
        ST_SCAN_END = 8'b0000_1000,
        ST_SUB_WR   = 8'b0001_0000,
        ST_P_CHK    = 8'b0010_0000,
        ST_P_WR     = 8'b0100_0000,
        ST_DONE     = 8'b1000_0000
    } state_t;

    function automatic logic [SW-1:0] slot_of(input logic [PW-1:0] ptr);
        logic [PW-1:0] s;
        s = (ptr >= PW'(RING_DEPTH)) ? (ptr - PW'(RING_DEPTH)) : ptr;
        return SW'(s);
    endfunction

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] ptr);
        return (ptr == PW'(2 * RING_DEPTH - 1)) ? '0 : (ptr + PW'(1));
    endfunction

    function automatic logic [FW-1:0] fill_of(input logic [PW-1:0] wp,
                                               input logic [PW-1:0] rp);
        logic [FW-1:0] f;
        if (wp >= rp)
        begin
            f = FW'(wp) - FW'(rp);
        end
        else
        begin
            f = FW'(wp) + FW'(2 * RING_DEPTH) - FW'(rp);
        end
        return f;
    endfunction

    function automatic logic [RAW-1:0] ring_addr(input logic [QW-1:0] q,
                                                  input logic [SW-1:0] s);
        return RAW'(RAW'(q) * RAW'(RING_DEPTH)) + RAW'(s);
    endfunction

    // registers
    state_t                 state_reg, state_next;
    in_item_t               item_reg, item_next;
    logic [3:0]             aq_reg;
    logic [7:0]             mask_reg;
    logic [CFG_W-1:0]       ceil_reg;
    logic [CW-1:0]          scan_cnt_reg, scan_cnt_next;
    logic                   rdv_reg, rdv_next;
    logic [QW-1:0]          rd_idx_reg, rd_idx_next;
    logic [ENT_W-1:0]       ent_reg, ent_next;
    out_item_t              res_reg, res_next;
    logic                   out_valid_reg, out_valid_next;
    out_item_t              out_data_reg, out_data_next;

    // memory ports
    logic                   qs_we, qs_re;
    logic [QW-1:0]          qs_wa, qs_ra;
    logic [ENT_W-1:0]       qs_wd, qs_rd;
    logic                   ring_we, ring_re;
    logic [RAW-1:0]         ring_wa, ring_ra;
    logic [RING_W-1:0]      ring_wd, ring_rd;

    // picker
    pick_ctl_t              pick_ctl;
    logic                   pick_found;
    logic [QW-1:0]          pick_idx;
    logic [ENT_W-1:0]       pick_ent;

    // misc
    logic                   in_accept;
    logic                   out_load;
    logic                   sel_ok;
    logic [QW-1:0]          sel_q;
    logic [CW-1:0]          n_act;
    logic                   scan_last;
    logic [THW-1:0]         threshold;
    logic [CHW-1:0]         charge_w;
    logic [15:0]            charge;
    logic [PW-1:0]          cand_wp, cand_rp;
    logic [TOTAL_W-1:0]     cand_total;
    logic                   cand_en;
    logic                   cand_ok;
    logic [PW-1:0]          best_wp, best_rp;
    logic [TOTAL_W-1:0]     best_total;
    logic [PW-1:0]          chk_wp, chk_rp;
    logic [PW-1:0]          cur_wp, cur_rp;
    logic [TOTAL_W-1:0]     cur_total;

    lctd_qstate #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_QUEUES)
    ) u_qstate (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (qs_we),
        .wr_addr (qs_wa),
        .wr_data (qs_wd),
        .rd_en   (qs_re),
        .rd_addr (qs_ra),
        .rd_data (qs_rd)
    );

    lctd_ram #(
        .WIDTH (RING_W),
        .DEPTH (RDEP)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_we),
        .wr_addr (ring_wa),
        .wr_data (ring_wd),
        .rd_en   (ring_re),
        .rd_addr (ring_ra),
        .rd_data (ring_rd)
    );

    lctd_picker #(
        .KEY_W (TOTAL_W),
        .PAY_W (ENT_W),
        .IDX_W (QW)
    ) u_picker (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (pick_ctl),
        .key          (cand_total),
        .idx          (rd_idx_reg),
        .payload      (qs_rd),
        .found        (pick_found),
        .best_idx     (pick_idx),
        .best_payload (pick_ent)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign sel_ok    = (32'(item_reg.queue_select) < NUM_QUEUES);
    assign sel_q     = QW'(item_reg.queue_select);
    assign n_act     = (32'(aq_reg) > NUM_QUEUES) ? CW'(NUM_QUEUES) : CW'(aq_reg);
    assign scan_last = (scan_cnt_reg == (n_act - CW'(1)));
    assign threshold = THW'(ceil_reg) * THW'(RING_DEPTH);

    // blocking tasks are charged the threshold; charge saturates at 16 bits
    assign charge_w = item_reg.task_cost[15] ? CHW'(threshold)
                                             : CHW'($unsigned(item_reg.task_cost));
    assign charge   = (charge_w > CHW'(16'hFFFF)) ? 16'hFFFF : charge_w[15:0];

    // candidate qualification on the entry just read during the scan
    assign cand_wp    = qs_rd[ENT_W-1 -: PW];
    assign cand_rp    = qs_rd[TOTAL_W +: PW];
    assign cand_total = qs_rd[TOTAL_W-1:0];
    assign cand_en    = (32'(rd_idx_reg) >= 8) ? 1'b1 : mask_reg[3'(rd_idx_reg)];
    assign cand_ok    = cand_en
                     && (fill_of(cand_wp, cand_rp) < FW'(RING_DEPTH))
                     && ((cand_total == '0) || (cand_total < TOTAL_W'(threshold)));

    assign pick_ctl.clear = in_accept;
    assign pick_ctl.cand  = rdv_reg && cand_ok;

    assign best_wp    = pick_ent[ENT_W-1 -: PW];
    assign best_rp    = pick_ent[TOTAL_W +: PW];
    assign best_total = pick_ent[TOTAL_W-1:0];
    assign chk_wp     = qs_rd[ENT_W-1 -: PW];
    assign chk_rp     = qs_rd[TOTAL_W +: PW];
    assign cur_wp     = ent_reg[ENT_W-1 -: PW];
    assign cur_rp     = ent_reg[TOTAL_W +: PW];
    assign cur_total  = ent_reg[TOTAL_W-1:0];

    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        scan_cnt_next = scan_cnt_reg;
        ent_next      = ent_reg;
        res_next      = res_reg;
        qs_re         = 1'b0;
        qs_ra         = sel_q;
        qs_we         = 1'b0;
        qs_wa         = sel_q;
        qs_wd         = {cur_wp, ptr_inc(cur_rp), cur_total - TOTAL_W'(ring_rd[15:0])};
        ring_re       = 1'b0;
        ring_ra       = ring_addr(sel_q, slot_of(chk_rp));
        ring_we       = 1'b0;
        ring_wa       = ring_addr(pick_idx, slot_of(best_wp));
        ring_wd       = {item_reg.task_handle, charge};
        out_load      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    item_next  = in_data;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (item_reg.op == OP_SUBMIT)
                begin
                    if (n_act == '0)
                    begin
                        res_next   = '{STATUS_NO_QUEUE, 3'd0, 32'd0, 16'd0};
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        scan_cnt_next = '0;
                        state_next    = ST_SCAN;
                    end
                end
                else if (!sel_ok)
                begin
                    res_next   = '{STATUS_EMPTY, item_reg.queue_select, 32'd0, 16'd0};
                    state_next = ST_DONE;
                end
                else
                begin
                    qs_re      = 1'b1;
                    qs_ra      = sel_q;
                    state_next = ST_P_CHK;
                end
            end
            ST_SCAN:
            begin
                qs_re         = 1'b1;
                qs_ra         = QW'(scan_cnt_reg);
                scan_cnt_next = scan_cnt_reg + CW'(1);
                if (scan_last)
                begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END:
            begin
                // last entry is sampled by the picker this cycle
                state_next = ST_SUB_WR;
            end
            ST_SUB_WR:
            begin
                if (pick_found)
                begin
                    ring_we  = 1'b1;
                    qs_we    = 1'b1;
                    qs_wa    = pick_idx;
                    qs_wd    = {ptr_inc(best_wp), best_rp, best_total + TOTAL_W'(charge)};
                    res_next = '{STATUS_ACCEPTED, 3'(pick_idx), 32'd0, 16'd0};
                end
                else
                begin
                    res_next = '{STATUS_NO_QUEUE, 3'd0, 32'd0, 16'd0};
                end
                state_next = ST_DONE;
            end
            ST_P_CHK:
            begin
                ent_next = qs_rd;
                if (chk_wp == chk_rp)
                begin
                    res_next   = '{STATUS_EMPTY, item_reg.queue_select, 32'd0, 16'd0};
                    state_next = ST_DONE;
                end
                else
                begin
                    ring_re    = 1'b1;
                    state_next = ST_P_WR;
                end
            end
            ST_P_WR:
            begin
                qs_we      = 1'b1;
                qs_wa      = sel_q;
                res_next   = '{STATUS_POPPED, item_reg.queue_select,
                               ring_rd[47:16], ring_rd[15:0]};
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rdv_next       = (state_reg == ST_SCAN);
    assign rd_idx_next    = QW'(scan_cnt_reg);
    assign out_valid_next = out_load ? 1'b1 : (out_valid_reg && out_stall);
    assign out_data_next  = out_load ? res_reg : out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rdv_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            aq_reg        <= ACTIVE_QUEUES_RST;
            mask_reg      <= ENABLE_MASK_RST;
            ceil_reg      <= COST_CEILING_RST;
        end
        else
        begin
            state_reg     <= state_next;
            rdv_reg       <= rdv_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ACTIVE_QUEUES: aq_reg   <= cfg_data[3:0];
                    CFG_ENABLE_MASK:   mask_reg <= cfg_data[7:0];
                    CFG_COST_CEILING:  ceil_reg <= cfg_data;
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        scan_cnt_reg <= scan_cnt_next;
        rd_idx_reg   <= rd_idx_next;
        ent_reg      <= ent_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    // one item in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n) in_accept |=> in_stall)
        else $error("input transfer accepted while an item is in flight");

    // non-pop results carry no task
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status != STATUS_POPPED))
        |-> ((out_data.popped_handle == 32'd0) && (out_data.popped_cost == 16'd0)))
        else $error("popped fields set on a non-pop result");

    // queue state is never read and written in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n) !(qs_we && qs_re))
        else $error("queue state read/write overlap");

    // the winner of a scan is an active queue
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SUB_WR) && pick_found) |-> (32'(pick_idx) < 32'(n_act)))
        else $error("picked queue outside the active range");

    // a ring write always comes with a queue state update
    assert property (@(posedge clk) disable iff (!rst_n) ring_we |-> qs_we)
        else $error("ring written without queue state update");

endmodule

`default_nettype wire
